>>> hdl/sic_pkg.sv
// Shared types and constants for the segment intersection classifier.
// Holds operand index maps, the product schedule and the result encoding.
// No dependencies.
package sic_pkg;

  // Width of every numeric result field.
  localparam int OUT_BITS = 51;

  // Order of the eight input coordinates on the packed point bus.
  localparam int NUM_COORDS = 8;
  localparam int COORD_AX = 0;
  localparam int COORD_AY = 1;
  localparam int COORD_BX = 2;
  localparam int COORD_BY = 3;
  localparam int COORD_CX = 4;
  localparam int COORD_CY = 5;
  localparam int COORD_DX = 6;
  localparam int COORD_DY = 7;

  // Coordinate differences formed in the first stage.
  localparam int NUM_DIFFS = 10;
  localparam int DIFF_BA_X = 0;
  localparam int DIFF_BA_Y = 1;
  localparam int DIFF_DC_X = 2;
  localparam int DIFF_DC_Y = 3;
  localparam int DIFF_CA_X = 4;
  localparam int DIFF_CA_Y = 5;
  localparam int DIFF_DA_X = 6;
  localparam int DIFF_DA_Y = 7;
  localparam int DIFF_BC_X = 8;
  localparam int DIFF_BC_Y = 9;

  // Cross products. Each area is product 2k minus product 2k+1.
  localparam int NUM_AREAS = 6;
  localparam int NUM_PRODS = 2 * NUM_AREAS;
  localparam int AREA_DEN  = 0;  // (D-C) x (B-A)
  localparam int AREA_SNUM = 1;  // -(C-A) x (D-A)
  localparam int AREA_TNUM = 2;  // (B-A) x (C-A)
  localparam int AREA_ABD  = 3;  // (B-A) x (D-A)
  localparam int AREA_CDA  = 4;  // (D-C) x (A-C)
  localparam int AREA_CDB  = 5;  // (D-C) x (B-C)

  localparam int PROD_LHS [NUM_PRODS] = '{
    DIFF_DC_X, DIFF_DC_Y,
    DIFF_CA_Y, DIFF_CA_X,
    DIFF_BA_X, DIFF_BA_Y,
    DIFF_BA_X, DIFF_BA_Y,
    DIFF_DC_Y, DIFF_DC_X,
    DIFF_DC_X, DIFF_DC_Y
  };
  localparam int PROD_RHS [NUM_PRODS] = '{
    DIFF_BA_Y, DIFF_BA_X,
    DIFF_DA_X, DIFF_DA_Y,
    DIFF_CA_Y, DIFF_CA_X,
    DIFF_DA_Y, DIFF_DA_X,
    DIFF_CA_X, DIFF_CA_Y,
    DIFF_BC_Y, DIFF_BC_X
  };

  // Span checks of the collinear path: does a point fall in the other
  // segment's coordinate range.
  typedef struct packed {
    logic c_in_ab;
    logic d_in_ab;
    logic a_in_cd;
    logic b_in_cd;
  } span_flags_t;

  typedef enum logic [1:0] {
    MEET_NONE    = 2'd0,
    MEET_CROSS   = 2'd1,
    MEET_TOUCH   = 2'd2,
    MEET_OVERLAP = 2'd3
  } meet_kind_e;

endpackage

>>> hdl/segment_intersection_classifier_core.sv
// Segment intersection classifier: four-stage pipeline that takes one request
// per cycle while the output is not stalled. A request passes four register
// stages in order: differences, products, areas, classification. Each of
// the twelve products has its own multiplier, registered in stage two.
// Reset (rst_ni, asynchronous, active low) empties every stage; no other state.
// Depends on sic_pkg and the four sic_*_stage modules.
module segment_intersection_classifier_core #(
  parameter int COORD_BITS = 24
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,

  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [COORD_BITS-1:0]          first_start_x_i,
  input  logic signed [COORD_BITS-1:0]          first_start_y_i,
  input  logic signed [COORD_BITS-1:0]          first_end_x_i,
  input  logic signed [COORD_BITS-1:0]          first_end_y_i,
  input  logic signed [COORD_BITS-1:0]          second_start_x_i,
  input  logic signed [COORD_BITS-1:0]          second_start_y_i,
  input  logic signed [COORD_BITS-1:0]          second_end_x_i,
  input  logic signed [COORD_BITS-1:0]          second_end_y_i,

  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [1:0]                            meet_kind_o,
  output logic signed [sic_pkg::OUT_BITS-1:0]   s_numerator_o,
  output logic signed [sic_pkg::OUT_BITS-1:0]   t_numerator_o,
  output logic signed [sic_pkg::OUT_BITS-1:0]   denominator_o
);

  // Each stage holds its request until the next stage has room, so a stall
  // at the output backs up one stage at a time and bubbles are squeezed out.
  // The input is ready whenever the first stage is empty or moving on.

  localparam int DiffBits = COORD_BITS + 1;
  localparam int ProdBits = 2 * DiffBits;
  localparam int AreaBits = ProdBits + 1;

  logic [sic_pkg::NUM_COORDS-1:0][COORD_BITS-1:0] coord;

  logic                                           diff_valid, diff_ready;
  logic [sic_pkg::NUM_DIFFS-1:0][DiffBits-1:0]    diff;
  sic_pkg::span_flags_t                           diff_span;

  logic                                           prod_valid, prod_ready;
  logic [sic_pkg::NUM_PRODS-1:0][ProdBits-1:0]    prod;
  sic_pkg::span_flags_t                           prod_span;

  logic                                           area_valid, area_ready;
  logic [sic_pkg::NUM_AREAS-1:0][AreaBits-1:0]    area;
  sic_pkg::span_flags_t                           area_span;

  sic_pkg::meet_kind_e                            kind;

  // Pack the points in the order the first stage expects.
  always_comb begin
    coord[sic_pkg::COORD_AX] = first_start_x_i;
    coord[sic_pkg::COORD_AY] = first_start_y_i;
    coord[sic_pkg::COORD_BX] = first_end_x_i;
    coord[sic_pkg::COORD_BY] = first_end_y_i;
    coord[sic_pkg::COORD_CX] = second_start_x_i;
    coord[sic_pkg::COORD_CY] = second_start_y_i;
    coord[sic_pkg::COORD_DX] = second_end_x_i;
    coord[sic_pkg::COORD_DY] = second_end_y_i;
  end

  // Stage one: the ten coordinate differences and the range half of each
  // between test, which only needs the raw coordinates.
  sic_diff_stage #(
    .COORD_BITS(COORD_BITS)
  ) u_diff (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .coord_i (coord),
    .valid_o (diff_valid),
    .ready_i (diff_ready),
    .diff_o  (diff),
    .span_o  (diff_span)
  );

  // Stage two: twelve products, one multiplier each.
  sic_product_stage #(
    .COORD_BITS(COORD_BITS)
  ) u_prod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (diff_valid),
    .ready_o (diff_ready),
    .diff_i  (diff),
    .span_i  (diff_span),
    .valid_o (prod_valid),
    .ready_i (prod_ready),
    .prod_o  (prod),
    .span_o  (prod_span)
  );

  // Stage three: the denominator, both numerators and the three extra
  // cross products used by the collinear path.
  sic_area_stage #(
    .COORD_BITS(COORD_BITS)
  ) u_area (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (prod_valid),
    .ready_o (prod_ready),
    .prod_i  (prod),
    .span_i  (prod_span),
    .valid_o (area_valid),
    .ready_i (area_ready),
    .area_o  (area),
    .span_o  (area_span)
  );

  // Stage four: span bounds, endpoint detection and the output register.
  // Results are zero for no meeting and for a collinear overlap.
  sic_classify_stage #(
    .COORD_BITS(COORD_BITS)
  ) u_classify (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (area_valid),
    .ready_o (area_ready),
    .area_i  (area),
    .span_i  (area_span),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .kind_o  (kind),
    .s_num_o (s_numerator_o),
    .t_num_o (t_numerator_o),
    .den_o   (denominator_o)
  );

  assign meet_kind_o = kind;

`ifndef NO_ASSERTIONS
  // No meeting and collinear overlap both carry all-zero numbers.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind == sic_pkg::MEET_NONE || kind == sic_pkg::MEET_OVERLAP)
    |-> (s_numerator_o == '0 && t_numerator_o == '0 && denominator_o == '0))
    else $error("non-meeting result carries nonzero numbers");

  // With exact outputs, a crossing or touch never has a zero denominator.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (AreaBits <= sic_pkg::OUT_BITS) &&
    (kind == sic_pkg::MEET_CROSS || kind == sic_pkg::MEET_TOUCH)
    |-> denominator_o != '0)
    else $error("crossing reported with zero denominator");

  // A proper crossing lies strictly inside both spans.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (AreaBits <= sic_pkg::OUT_BITS) && kind == sic_pkg::MEET_CROSS
    |-> (s_numerator_o != '0 && s_numerator_o != denominator_o &&
         t_numerator_o != '0 && t_numerator_o != denominator_o))
    else $error("proper crossing reported at an endpoint");

  // A request taken by the first stage must occupy it next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> diff_valid)
    else $error("accepted request did not enter the pipeline");
`endif

endmodule

>>> hdl/sic_diff_stage.sv
// First pipeline stage: coordinate differences and collinear span checks.
// Depends on sic_pkg.
module sic_diff_stage #(
  parameter int COORD_BITS = 24
) (
  input  logic                                                 clk_i,
  input  logic                                                 rst_ni,
  input  logic                                                 valid_i,
  output logic                                                 ready_o,
  input  logic [sic_pkg::NUM_COORDS-1:0][COORD_BITS-1:0]       coord_i,
  output logic                                                 valid_o,
  input  logic                                                 ready_i,
  output logic [sic_pkg::NUM_DIFFS-1:0][COORD_BITS:0]          diff_o,
  output sic_pkg::span_flags_t                                 span_o
);

  localparam int DiffBits = COORD_BITS + 1;

  logic                                            valid_q;
  logic [sic_pkg::NUM_DIFFS-1:0][DiffBits-1:0]     diff_d, diff_q;
  sic_pkg::span_flags_t                            span_d, span_q;

  // Range part of the between test: x range unless the segment is vertical.
  function automatic logic in_span(input logic signed [COORD_BITS-1:0] px,
                                   input logic signed [COORD_BITS-1:0] py,
                                   input logic signed [COORD_BITS-1:0] qx,
                                   input logic signed [COORD_BITS-1:0] qy,
                                   input logic signed [COORD_BITS-1:0] rx,
                                   input logic signed [COORD_BITS-1:0] ry);
    logic hit;
    if (px != qx) begin
      hit = (px <= rx && rx <= qx) || (px >= rx && rx >= qx);
    end else begin
      hit = (py <= ry && ry <= qy) || (py >= ry && ry >= qy);
    end
    return hit;
  endfunction

  function automatic logic [DiffBits-1:0] sub(input logic [COORD_BITS-1:0] q,
                                              input logic [COORD_BITS-1:0] p);
    logic signed [DiffBits-1:0] r;
    r = DiffBits'($signed(q)) - DiffBits'($signed(p));
    return r;
  endfunction

  always_comb begin
    diff_d[sic_pkg::DIFF_BA_X] = sub(coord_i[sic_pkg::COORD_BX], coord_i[sic_pkg::COORD_AX]);
    diff_d[sic_pkg::DIFF_BA_Y] = sub(coord_i[sic_pkg::COORD_BY], coord_i[sic_pkg::COORD_AY]);
    diff_d[sic_pkg::DIFF_DC_X] = sub(coord_i[sic_pkg::COORD_DX], coord_i[sic_pkg::COORD_CX]);
    diff_d[sic_pkg::DIFF_DC_Y] = sub(coord_i[sic_pkg::COORD_DY], coord_i[sic_pkg::COORD_CY]);
    diff_d[sic_pkg::DIFF_CA_X] = sub(coord_i[sic_pkg::COORD_CX], coord_i[sic_pkg::COORD_AX]);
    diff_d[sic_pkg::DIFF_CA_Y] = sub(coord_i[sic_pkg::COORD_CY], coord_i[sic_pkg::COORD_AY]);
    diff_d[sic_pkg::DIFF_DA_X] = sub(coord_i[sic_pkg::COORD_DX], coord_i[sic_pkg::COORD_AX]);
    diff_d[sic_pkg::DIFF_DA_Y] = sub(coord_i[sic_pkg::COORD_DY], coord_i[sic_pkg::COORD_AY]);
    diff_d[sic_pkg::DIFF_BC_X] = sub(coord_i[sic_pkg::COORD_BX], coord_i[sic_pkg::COORD_CX]);
    diff_d[sic_pkg::DIFF_BC_Y] = sub(coord_i[sic_pkg::COORD_BY], coord_i[sic_pkg::COORD_CY]);

    span_d.c_in_ab = in_span(coord_i[sic_pkg::COORD_AX], coord_i[sic_pkg::COORD_AY],
                             coord_i[sic_pkg::COORD_BX], coord_i[sic_pkg::COORD_BY],
                             coord_i[sic_pkg::COORD_CX], coord_i[sic_pkg::COORD_CY]);
    span_d.d_in_ab = in_span(coord_i[sic_pkg::COORD_AX], coord_i[sic_pkg::COORD_AY],
                             coord_i[sic_pkg::COORD_BX], coord_i[sic_pkg::COORD_BY],
                             coord_i[sic_pkg::COORD_DX], coord_i[sic_pkg::COORD_DY]);
    span_d.a_in_cd = in_span(coord_i[sic_pkg::COORD_CX], coord_i[sic_pkg::COORD_CY],
                             coord_i[sic_pkg::COORD_DX], coord_i[sic_pkg::COORD_DY],
                             coord_i[sic_pkg::COORD_AX], coord_i[sic_pkg::COORD_AY]);
    span_d.b_in_cd = in_span(coord_i[sic_pkg::COORD_CX], coord_i[sic_pkg::COORD_CY],
                             coord_i[sic_pkg::COORD_DX], coord_i[sic_pkg::COORD_DY],
                             coord_i[sic_pkg::COORD_BX], coord_i[sic_pkg::COORD_BY]);
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      diff_q <= diff_d;
      span_q <= span_d;
    end
  end

  assign valid_o = valid_q;
  assign diff_o  = diff_q;
  assign span_o  = span_q;

endmodule

>>> hdl/sic_product_stage.sv
// Second pipeline stage: the twelve signed difference products.
// Depends on sic_pkg.
module sic_product_stage #(
  parameter int COORD_BITS = 24
) (
  input  logic                                                 clk_i,
  input  logic                                                 rst_ni,
  input  logic                                                 valid_i,
  output logic                                                 ready_o,
  input  logic [sic_pkg::NUM_DIFFS-1:0][COORD_BITS:0]          diff_i,
  input  sic_pkg::span_flags_t                                 span_i,
  output logic                                                 valid_o,
  input  logic                                                 ready_i,
  output logic [sic_pkg::NUM_PRODS-1:0][2*COORD_BITS+1:0]      prod_o,
  output sic_pkg::span_flags_t                                 span_o
);

  localparam int DiffBits = COORD_BITS + 1;
  localparam int ProdBits = 2 * DiffBits;

  logic                                            valid_q;
  logic [sic_pkg::NUM_PRODS-1:0][ProdBits-1:0]     prod_d, prod_q;
  sic_pkg::span_flags_t                            span_q;

  for (genvar k = 0; k < sic_pkg::NUM_PRODS; k++) begin : g_mul
    logic signed [DiffBits-1:0] lhs, rhs;
    logic signed [ProdBits-1:0] prod;
    assign lhs = $signed(diff_i[sic_pkg::PROD_LHS[k]]);
    assign rhs = $signed(diff_i[sic_pkg::PROD_RHS[k]]);
    assign prod = lhs * rhs;
    assign prod_d[k] = prod;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      prod_q <= prod_d;
      span_q <= span_i;
    end
  end

  assign valid_o = valid_q;
  assign prod_o  = prod_q;
  assign span_o  = span_q;

endmodule

>>> hdl/sic_area_stage.sv
// Third pipeline stage: each cross product from its pair of products.
// Depends on sic_pkg.
module sic_area_stage #(
  parameter int COORD_BITS = 24
) (
  input  logic                                                 clk_i,
  input  logic                                                 rst_ni,
  input  logic                                                 valid_i,
  output logic                                                 ready_o,
  input  logic [sic_pkg::NUM_PRODS-1:0][2*COORD_BITS+1:0]      prod_i,
  input  sic_pkg::span_flags_t                                 span_i,
  output logic                                                 valid_o,
  input  logic                                                 ready_i,
  output logic [sic_pkg::NUM_AREAS-1:0][2*COORD_BITS+2:0]      area_o,
  output sic_pkg::span_flags_t                                 span_o
);

  localparam int ProdBits = 2 * COORD_BITS + 2;
  localparam int AreaBits = ProdBits + 1;

  logic                                            valid_q;
  logic [sic_pkg::NUM_AREAS-1:0][AreaBits-1:0]     area_d, area_q;
  sic_pkg::span_flags_t                            span_q;

  for (genvar k = 0; k < sic_pkg::NUM_AREAS; k++) begin : g_sub
    logic signed [ProdBits-1:0] pos, neg;
    logic signed [AreaBits-1:0] diff;
    assign pos = $signed(prod_i[2*k]);
    assign neg = $signed(prod_i[2*k+1]);
    assign diff = pos - neg;
    assign area_d[k] = diff;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      area_q <= area_d;
      span_q <= span_i;
    end
  end

  assign valid_o = valid_q;
  assign area_o  = area_q;
  assign span_o  = span_q;

endmodule

>>> hdl/sic_classify_stage.sv
// Last pipeline stage: classifies the meeting and drives the output register.
// Depends on sic_pkg.
module sic_classify_stage #(
  parameter int COORD_BITS = 24
) (
  input  logic                                                 clk_i,
  input  logic                                                 rst_ni,
  input  logic                                                 valid_i,
  output logic                                                 ready_o,
  input  logic [sic_pkg::NUM_AREAS-1:0][2*COORD_BITS+2:0]      area_i,
  input  sic_pkg::span_flags_t                                 span_i,
  output logic                                                 valid_o,
  input  logic                                                 ready_i,
  output sic_pkg::meet_kind_e                                  kind_o,
  output logic signed [sic_pkg::OUT_BITS-1:0]                  s_num_o,
  output logic signed [sic_pkg::OUT_BITS-1:0]                  t_num_o,
  output logic signed [sic_pkg::OUT_BITS-1:0]                  den_o
);

  localparam int AreaBits = 2 * COORD_BITS + 3;
  localparam int OutBits  = sic_pkg::OUT_BITS;

  logic signed [AreaBits-1:0] den, snum, tnum, abd, cda, cdb;
  logic                       c_ab, d_ab, a_cd, b_cd, overlap;
  logic                       s_out, t_out, at_end;

  logic                       valid_q;
  sic_pkg::meet_kind_e        kind_d, kind_q;
  logic signed [OutBits-1:0]  s_d, t_d, den_d, s_q, t_q, den_q;

  assign den  = $signed(area_i[sic_pkg::AREA_DEN]);
  assign snum = $signed(area_i[sic_pkg::AREA_SNUM]);
  assign tnum = $signed(area_i[sic_pkg::AREA_TNUM]);
  assign abd  = $signed(area_i[sic_pkg::AREA_ABD]);
  assign cda  = $signed(area_i[sic_pkg::AREA_CDA]);
  assign cdb  = $signed(area_i[sic_pkg::AREA_CDB]);

  // Collinear overlap needs any two endpoints on the other segment.
  assign c_ab = (tnum == '0) && span_i.c_in_ab;
  assign d_ab = (abd  == '0) && span_i.d_in_ab;
  assign a_cd = (cda  == '0) && span_i.a_in_cd;
  assign b_cd = (cdb  == '0) && span_i.b_in_cd;
  assign overlap = (c_ab && d_ab) || (a_cd && b_cd) || (c_ab && b_cd) ||
                   (c_ab && a_cd) || (d_ab && b_cd) || (d_ab && a_cd);

  assign s_out  = (snum > 0 && snum > den) || (snum < 0 && snum < den);
  assign t_out  = (tnum > 0 && tnum > den) || (tnum < 0 && tnum < den);
  assign at_end = (snum == '0) || (snum == den) || (tnum == '0) || (tnum == den);

  always_comb begin
    kind_d = sic_pkg::MEET_NONE;
    s_d    = '0;
    t_d    = '0;
    den_d  = '0;
    priority if (den == '0) begin
      if (tnum == '0 && overlap) begin
        kind_d = sic_pkg::MEET_OVERLAP;
      end
    end else if (s_out || t_out) begin
      kind_d = sic_pkg::MEET_NONE;
    end else begin
      kind_d = at_end ? sic_pkg::MEET_TOUCH : sic_pkg::MEET_CROSS;
      s_d    = OutBits'(snum);
      t_d    = OutBits'(tnum);
      den_d  = OutBits'(den);
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      kind_q <= kind_d;
      s_q    <= s_d;
      t_q    <= t_d;
      den_q  <= den_d;
    end
  end

  assign valid_o = valid_q;
  assign kind_o  = kind_q;
  assign s_num_o = s_q;
  assign t_num_o = t_q;
  assign den_o   = den_q;

endmodule
